### design/tcw_pkg.sv
// package for the text console cell writer: field widths, character codes,
// command codes, word and cell types, and the microcode table of the sequencer
// no dependencies
package tcw_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  localparam int CMD_W  = 3;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int CELL_W = CHAR_W + ATTR_W;
  localparam int STEP_W = 5;

  localparam logic [CHAR_W-1:0] CODE_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CODE_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CODE_SPACE     = 8'h20;
  localparam logic [ATTR_W-1:0] DEFAULT_ATTR   = 8'h0F;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUT_CUR   = 3'd0,
    CMD_PUT_POS   = 3'd1,
    CMD_BACKSPACE = 3'd2,
    CMD_CLEAR     = 3'd3,
    CMD_READ      = 3'd4
  } cmd_e;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [CHAR_W-1:0] character;
    logic [ATTR_W-1:0] attribute;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
  } tcw_in_t;

  typedef struct packed {
    logic [COL_W-1:0]  cursor_col;
    logic [ROW_W-1:0]  cursor_row;
    logic [CHAR_W-1:0] cell_char;
    logic [ATTR_W-1:0] cell_attr;
    logic              scrolled;
  } tcw_out_t;

  typedef struct packed {
    logic [ATTR_W-1:0] attr;
    logic [CHAR_W-1:0] code;
  } cell_t;

  // microprogram steps
  typedef enum logic [STEP_W-1:0] {
    S_INIT, S_INITF, S_IDLE,
    S_PUT, S_PUTA, S_PUTW, S_ADV, S_NL, S_CHK,
    S_COPY, S_DRAIN, S_ZERO, S_UP, S_CUR, S_DONE,
    S_BACK, S_BACKA, S_BACKW,
    S_CLR, S_CLRF, S_CLRE,
    S_READ, S_READA, S_READR, S_READC
  } step_e;

  typedef enum logic [2:0] {
    POS_HOLD, POS_LOAD, POS_TARGET, POS_NEXT, POS_NEWLINE, POS_BACK, POS_UP, POS_HOME
  } pos_op_e;

  typedef enum logic [2:0] {
    RAM_NONE, RAM_WRITE_CHAR, RAM_WRITE_SPACE, RAM_READ, RAM_FILL_BLANK, RAM_FILL_ZERO,
    RAM_COPY
  } ram_op_e;

  typedef enum logic [1:0] {
    SW_HOLD, SW_CLEAR, SW_INC
  } sweep_op_e;

  typedef enum logic [3:0] {
    JC_NEXT, JC_GOTO, JC_LOOP_COPY, JC_LOOP_FILL, JC_IF_NEWLINE, JC_IF_BKSP,
    JC_IF_NO_SCROLL, JC_DISPATCH, JC_RETIRE
  } jc_e;

  typedef struct packed {
    pos_op_e   pos_op;
    logic      addr_ld;
    ram_op_e   ram_op;
    logic      attr_plain;
    sweep_op_e sw_op;
    logic      set_scr;
    logic      rd_cap;
    logic      cur_ld;
    jc_e       jc;
    step_e     target;
  } ctl_t;

  typedef struct packed {
    logic is_newline;
    logic is_bksp;
    logic no_scroll;
    logic copy_last;
    logic fill_last;
  } stat_t;

  localparam ctl_t CTL_NOP = '{
    pos_op: POS_HOLD, addr_ld: 1'b0, ram_op: RAM_NONE, attr_plain: 1'b0,
    sw_op: SW_HOLD, set_scr: 1'b0, rd_cap: 1'b0, cur_ld: 1'b0,
    jc: JC_NEXT, target: S_INIT
  };

  // entry step for each command
  function automatic step_e dispatch(logic [CMD_W-1:0] cmd);
    step_e s;
    unique case (cmd) inside
      CMD_PUT_CUR, CMD_PUT_POS: s = S_PUT;
      CMD_BACKSPACE:            s = S_BACK;
      CMD_CLEAR:                s = S_CLR;
      CMD_READ:                 s = S_READ;
      default:                  s = S_DONE;
    endcase
    return s;
  endfunction

  // control store
  function automatic ctl_t ucode_word(step_e s);
    ctl_t w;
    w = CTL_NOP;
    unique case (s)
      S_INIT:  w.sw_op = SW_CLEAR;
      S_INITF: begin
        w.ram_op = RAM_FILL_ZERO; w.sw_op = SW_INC;
        w.jc = JC_LOOP_FILL; w.target = S_INITF;
      end
      S_IDLE:  w.jc = JC_DISPATCH;
      S_PUT:   w.pos_op = POS_LOAD;
      S_PUTA:  begin
        w.addr_ld = 1'b1; w.jc = JC_IF_NEWLINE; w.target = S_NL;
      end
      S_PUTW:  begin
        w.ram_op = RAM_WRITE_CHAR; w.jc = JC_IF_BKSP; w.target = S_CUR;
      end
      S_ADV:   begin
        w.pos_op = POS_NEXT; w.jc = JC_GOTO; w.target = S_CHK;
      end
      S_NL:    w.pos_op = POS_NEWLINE;
      S_CHK:   begin
        w.sw_op = SW_CLEAR; w.jc = JC_IF_NO_SCROLL; w.target = S_CUR;
      end
      S_COPY:  begin
        w.ram_op = RAM_COPY; w.sw_op = SW_INC; w.set_scr = 1'b1;
        w.jc = JC_LOOP_COPY; w.target = S_COPY;
      end
      S_DRAIN: w.jc = JC_NEXT;
      S_ZERO:  begin
        w.ram_op = RAM_FILL_ZERO; w.sw_op = SW_INC;
        w.jc = JC_LOOP_FILL; w.target = S_ZERO;
      end
      S_UP:    w.pos_op = POS_UP;
      S_CUR:   w.cur_ld = 1'b1;
      S_DONE:  begin
        w.jc = JC_RETIRE; w.target = S_IDLE;
      end
      S_BACK:  w.pos_op = POS_BACK;
      S_BACKA: w.addr_ld = 1'b1;
      S_BACKW: begin
        w.ram_op = RAM_WRITE_SPACE; w.attr_plain = 1'b1;
        w.jc = JC_GOTO; w.target = S_CUR;
      end
      S_CLR:   begin
        w.sw_op = SW_CLEAR; w.pos_op = POS_HOME;
      end
      S_CLRF:  begin
        w.ram_op = RAM_FILL_BLANK; w.attr_plain = 1'b1; w.sw_op = SW_INC;
        w.jc = JC_LOOP_FILL; w.target = S_CLRF;
      end
      S_CLRE:  begin
        w.jc = JC_GOTO; w.target = S_CUR;
      end
      S_READ:  w.pos_op = POS_TARGET;
      S_READA: w.addr_ld = 1'b1;
      S_READR: w.ram_op = RAM_READ;
      S_READC: begin
        w.rd_cap = 1'b1; w.jc = JC_GOTO; w.target = S_DONE;
      end
      default: begin
        w.jc = JC_GOTO; w.target = S_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

### design/tcw_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/tcw_sequencer.sv
// microprogram sequencer: step counter, control store lookup, jump logic
// depends on tcw_pkg
module tcw_sequencer import tcw_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [CMD_W-1:0] cmd,
  input  logic             out_free,
  input  stat_t            stat,
  output ctl_t             ctl
);

  step_e upc;
  step_e upc_next;
  step_e upc_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= S_INIT;
    end else begin
      upc <= upc_next;
    end
  end

  always_comb begin
    ctl     = ucode_word(upc);
    upc_inc = step_e'(upc + STEP_W'(1));
    unique case (ctl.jc)
      JC_NEXT:         upc_next = upc_inc;
      JC_GOTO:         upc_next = ctl.target;
      JC_LOOP_COPY:    upc_next = stat.copy_last ? upc_inc : ctl.target;
      JC_LOOP_FILL:    upc_next = stat.fill_last ? upc_inc : ctl.target;
      JC_IF_NEWLINE:   upc_next = stat.is_newline ? ctl.target : upc_inc;
      JC_IF_BKSP:      upc_next = stat.is_bksp ? ctl.target : upc_inc;
      JC_IF_NO_SCROLL: upc_next = stat.no_scroll ? ctl.target : upc_inc;
      JC_DISPATCH:     upc_next = accept ? dispatch(cmd) : upc;
      JC_RETIRE:       upc_next = out_free ? ctl.target : upc;
      default:         upc_next = S_IDLE;
    endcase
  end

endmodule

### design/tcw_datapath.sv
// datapath: held input word, cursor and working position, cell address,
// sweep counter, scroll copy pipeline and the cell ram
// depends on tcw_pkg and tcw_ram
module tcw_datapath import tcw_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  ctl_t              ctl,
  input  logic              accept,
  input  tcw_in_t           in_word,
  input  logic [ATTR_W-1:0] colour_override,
  output stat_t             stat,
  output tcw_out_t          result
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS + 1);
  localparam int CRW   = $clog2(ROWS);

  tcw_in_t           word;
  logic [CW-1:0]     cur_col;
  logic [CRW-1:0]    cur_row;
  logic [CW-1:0]     pos_col, pos_col_next;
  logic [RW-1:0]     pos_row, pos_row_next;
  logic [CW-1:0]     tgt_col;
  logic [RW-1:0]     tgt_row;
  logic [AW-1:0]     addr;
  logic [AW-1:0]     sweep;
  logic              cp_valid;
  logic [AW-1:0]     cp_addr;
  logic [CHAR_W-1:0] rd_char;
  logic [ATTR_W-1:0] rd_attr;
  logic              scr;
  logic [ATTR_W-1:0] attr_base;
  logic [ATTR_W-1:0] attr_f;
  logic              we;
  logic [AW-1:0]     waddr;
  cell_t             wcell;
  logic [AW-1:0]     raddr;
  logic [CELL_W-1:0] rdata;
  cell_t             rcell;

  // position clamped into the grid
  assign tgt_col = (int'(word.col) >= COLUMNS) ? CW'(COLUMNS - 1) : CW'(word.col);
  assign tgt_row = (int'(word.row) >= ROWS) ? RW'(ROWS - 1) : RW'(word.row);

  always_comb begin
    pos_col_next = pos_col;
    pos_row_next = pos_row;
    unique case (ctl.pos_op)
      POS_HOLD: ;
      POS_LOAD: begin
        if (word.cmd == CMD_PUT_POS) begin
          pos_col_next = tgt_col;
          pos_row_next = tgt_row;
        end else begin
          pos_col_next = cur_col;
          pos_row_next = RW'(cur_row);
        end
      end
      POS_TARGET: begin
        pos_col_next = tgt_col;
        pos_row_next = tgt_row;
      end
      POS_NEXT: begin
        if (pos_col == CW'(COLUMNS - 1)) begin
          pos_col_next = '0;
          pos_row_next = pos_row + RW'(1);
        end else begin
          pos_col_next = pos_col + CW'(1);
        end
      end
      POS_NEWLINE: begin
        pos_col_next = '0;
        pos_row_next = pos_row + RW'(1);
      end
      POS_BACK: begin
        if (cur_col != '0) begin
          pos_col_next = cur_col - CW'(1);
          pos_row_next = RW'(cur_row);
        end else if (cur_row != '0) begin
          pos_col_next = CW'(COLUMNS - 1);
          pos_row_next = RW'(cur_row) - RW'(1);
        end else begin
          pos_col_next = '0;
          pos_row_next = '0;
        end
      end
      POS_UP:   pos_row_next = pos_row - RW'(1);
      POS_HOME: begin
        pos_col_next = '0;
        pos_row_next = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_col  <= '0;
      cur_row  <= '0;
      cp_valid <= 1'b0;
    end else begin
      if (ctl.cur_ld) begin
        cur_col <= pos_col;
        cur_row <= CRW'(pos_row);
      end
      cp_valid <= (ctl.ram_op == RAM_COPY);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      word    <= in_word;
      rd_char <= '0;
      rd_attr <= '0;
      scr     <= 1'b0;
    end else begin
      if (ctl.rd_cap) begin
        rd_char <= rcell.code;
        rd_attr <= rcell.attr;
      end
      if (ctl.set_scr) begin
        scr <= 1'b1;
      end
    end
    pos_col <= pos_col_next;
    pos_row <= pos_row_next;
    if (ctl.addr_ld) begin
      addr <= AW'(int'(pos_row) * COLUMNS + int'(pos_col));
    end
    unique case (ctl.sw_op)
      SW_CLEAR: sweep <= '0;
      SW_INC:   sweep <= sweep + AW'(1);
      default:  sweep <= sweep;
    endcase
    cp_addr <= sweep;
  end

  // attribute 0 means white on black, a nonzero override wins
  assign attr_base = ctl.attr_plain ? DEFAULT_ATTR : word.attribute;
  assign attr_f    = (colour_override != '0) ? colour_override :
                     ((attr_base == '0) ? DEFAULT_ATTR : attr_base);

  assign rcell = cell_t'(rdata);

  always_comb begin
    we    = 1'b0;
    waddr = addr;
    wcell = '{attr: attr_f, code: CODE_SPACE};
    raddr = addr;
    if (cp_valid) begin
      // copy write lands in the cycle after its read
      we    = 1'b1;
      waddr = cp_addr;
      wcell = rcell;
    end
    unique case (ctl.ram_op)
      RAM_NONE, RAM_READ: ;
      RAM_WRITE_CHAR: begin
        we         = 1'b1;
        wcell.code = (word.character == CODE_BACKSPACE) ? CODE_SPACE : word.character;
      end
      RAM_WRITE_SPACE: we = 1'b1;
      RAM_FILL_BLANK: begin
        we    = 1'b1;
        waddr = sweep;
      end
      RAM_FILL_ZERO: begin
        we    = 1'b1;
        waddr = sweep;
        wcell = '0;
      end
      RAM_COPY: raddr = AW'(int'(sweep) + COLUMNS);
      default: ;
    endcase
  end

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_cells (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wcell),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign stat.is_newline = (word.character == CODE_NEWLINE);
  assign stat.is_bksp    = (word.character == CODE_BACKSPACE);
  assign stat.no_scroll  = (pos_row != RW'(ROWS));
  assign stat.copy_last  = (sweep == AW'(CELLS - COLUMNS - 1));
  assign stat.fill_last  = (sweep == AW'(CELLS - 1));

  assign result.cursor_col = COL_W'(cur_col);
  assign result.cursor_row = ROW_W'(cur_row);
  assign result.cell_char  = rd_char;
  assign result.cell_attr  = rd_attr;
  assign result.scrolled   = scr;

endmodule

### design/text_console_cell_writer.sv
// top level of the text console cell writer
// depends on tcw_pkg, tcw_sequencer, tcw_datapath (which holds tcw_ram)
//
// text-mode console: a COLUMNS x ROWS grid of 16-bit cells (attribute in the
// upper byte, character code in the lower byte) plus a cursor, driven by a
// small microprogram over one single-port-write ram. one command word in gives
// one result word out, holding the cursor after the command, the cell read by
// a read command (zero otherwise) and a scroll flag. words are taken one at a
// time. a put that runs past the last cell scrolls: the row copy (one cell per
// cycle, read and write overlapped), a drain step, the zero fill of the bottom
// row and the cursor step up. a stalled result word holds the sequencer on its
// last step. after reset a clearing pass zeroes the grid, during which in_stall
// is high; write the colour override register only between commands, since a
// command in progress uses it as it runs.
module text_console_cell_writer import tcw_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  // colour override register
  input  logic              cfg_wen,
  input  logic [ATTR_W-1:0] cfg_wdata,
  // command words
  input  logic              in_valid,
  output logic              in_stall,
  input  tcw_in_t           in_word,
  // result words
  output logic              out_valid,
  input  logic              out_stall,
  output tcw_out_t          out_word
);

  logic              accept;
  logic              out_free;
  logic              retire;
  logic [ATTR_W-1:0] colour_override;
  ctl_t              ctl;
  stat_t             stat;
  tcw_out_t          result;

  // only the idle step takes a command word
  assign in_stall = (ctl.jc != JC_DISPATCH);
  assign accept   = in_valid && !in_stall;

  // output register can load when empty or being drained this cycle
  assign out_free = !out_valid || !out_stall;
  assign retire   = (ctl.jc == JC_RETIRE) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      colour_override <= '0;
    end else if (cfg_wen) begin
      colour_override <= cfg_wdata;
    end
  end

  // result word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (retire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (retire) begin
      out_word <= result;
    end
  end

  tcw_sequencer u_seq (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .cmd      (in_word.cmd),
    .out_free (out_free),
    .stat     (stat),
    .ctl      (ctl)
  );

  tcw_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .ctl             (ctl),
    .accept          (accept),
    .in_word         (in_word),
    .colour_override (colour_override),
    .stat            (stat),
    .result          (result)
  );

endmodule

### verif/text_console_cell_writer_test.sv
// testbench for text_console_cell_writer: directed and random console commands checked
// against a cycle-free screen predictor, with random idling on both word channels
// depends on tcw_pkg and the design files
`timescale 1ns / 100ps

module text_console_cell_writer_test import tcw_pkg::*; ();

  localparam int COLS  = COLUMNS_DEF;
  localparam int LINES = ROWS_DEF;
  localparam int CELLS = COLS * LINES;
  localparam int COL_MAX = 2 ** COL_W - 1;
  localparam int ROW_MAX = 2 ** ROW_W - 1;
  localparam int CMD_MAX = 2 ** CMD_W - 1;
  localparam int REPORT_LIMIT = 10;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_wen = 1'b0;
  logic [ATTR_W-1:0] cfg_wdata = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  tcw_in_t           in_word = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  tcw_out_t          out_word;

  text_console_cell_writer #(
    .COLUMNS (COLS),
    .ROWS    (LINES)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  always #6 clk = ~clk;

  // predicted screen contents, cursor (as a linear cell index) and colour register
  cell_t       screen [CELLS];
  int          cursor_pos = 0;
  logic [7:0]  colour_reg = '0;

  // results predicted at command accept, oldest first
  tcw_out_t    expected_results [$];

  // idling control: calm means no gaps on that side
  bit          sender_calm = 1'b0;
  bit          receiver_calm = 1'b0;
  int          hold_request = 0;

  int          failures = 0;
  int          commands_sent = 0;
  int          reads_sent = 0;
  int          clears_sent = 0;
  int          scrolls_expected = 0;
  int          results_checked = 0;
  int          colour_settings = 0;

  initial begin
    foreach (screen[i]) screen[i] = '0;
  end

  function automatic int draw_gap(input bit calm);
    return calm ? 0 : $urandom_range(0, 10);
  endfunction

  // attribute that lands in a written cell: zero means white on black, override wins
  function automatic logic [7:0] written_attr(input logic [7:0] a);
    logic [7:0] r;
    r = (a == '0) ? DEFAULT_ATTR : a;
    if (colour_reg != '0) r = colour_reg;
    return r;
  endfunction

  // out-of-range coordinates saturate to the last column or row
  function automatic int target_index(input logic [COL_W-1:0] c, input logic [ROW_W-1:0] r);
    int cc;
    int rr;
    cc = (c >= COLS) ? COLS - 1 : int'(c);
    rr = (r >= LINES) ? LINES - 1 : int'(r);
    return rr * COLS + cc;
  endfunction

  // applies one command to the predicted console and returns its result word
  function automatic tcw_out_t predict_console(input tcw_in_t w);
    tcw_out_t res;
    int       p;
    int       i;
    res = '0;
    case (w.cmd)
      CMD_PUT_CUR, CMD_PUT_POS: begin
        p = (w.cmd == CMD_PUT_POS) ? target_index(w.col, w.row) : cursor_pos;
        if (w.character == CODE_NEWLINE) begin
          p = (p / COLS + 1) * COLS;
        end else if (w.character == CODE_BACKSPACE) begin
          screen[p] = '{attr: written_attr(w.attribute), code: CODE_SPACE};
        end else begin
          screen[p] = '{attr: written_attr(w.attribute), code: w.character};
          p++;
        end
        // ran off the end: everything moves up a row, bottom row zeroed
        if (p >= CELLS) begin
          for (i = 0; i < CELLS - COLS; i++) screen[i] = screen[i + COLS];
          for (i = CELLS - COLS; i < CELLS; i++) screen[i] = '0;
          p -= COLS;
          res.scrolled = 1'b1;
        end
        cursor_pos = p;
      end
      CMD_BACKSPACE: begin
        if (cursor_pos > 0) cursor_pos--;
        screen[cursor_pos] = '{attr: written_attr(DEFAULT_ATTR), code: CODE_SPACE};
      end
      CMD_CLEAR: begin
        for (i = 0; i < CELLS; i++)
          screen[i] = '{attr: written_attr(DEFAULT_ATTR), code: CODE_SPACE};
        cursor_pos = 0;
      end
      CMD_READ: begin
        p = target_index(w.col, w.row);
        res.cell_char = screen[p].code;
        res.cell_attr = screen[p].attr;
      end
      default: ;
    endcase
    res.cursor_col = COL_W'(cursor_pos % COLS);
    res.cursor_row = ROW_W'(cursor_pos / COLS);
    return res;
  endfunction

  function automatic tcw_in_t make_command(input logic [CMD_W-1:0] op, input logic [7:0] code,
                                           input logic [7:0] attr, input int c, input int r);
    tcw_in_t w;
    w.cmd       = op;
    w.character = code;
    w.attribute = attr;
    w.col       = COL_W'(c);
    w.row       = ROW_W'(r);
    return w;
  endfunction

  // mostly text at the cursor with newlines, some jumps, erases, reads and rare clears
  function automatic tcw_in_t random_command();
    tcw_in_t w;
    int      pick;
    int      p;
    w.cmd       = CMD_PUT_CUR;
    w.character = 8'($urandom_range(0, 255));
    w.attribute = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
    w.col = ($urandom_range(0, 7) == 0) ? COL_W'($urandom_range(COLS, COL_MAX))
                                        : COL_W'($urandom_range(0, COLS - 1));
    w.row = ($urandom_range(0, 7) == 0) ? ROW_W'($urandom_range(LINES, ROW_MAX))
                                        : ROW_W'($urandom_range(0, LINES - 1));
    pick = $urandom_range(0, 199);
    if (pick < 100) begin
      w.cmd = CMD_PUT_CUR;
    end else if (pick < 118) begin
      w.cmd = CMD_PUT_CUR;
      w.character = CODE_NEWLINE;
    end else if (pick < 126) begin
      w.cmd = (pick < 122) ? CMD_PUT_CUR : CMD_PUT_POS;
      w.character = CODE_BACKSPACE;
    end else if (pick < 146) begin
      w.cmd = CMD_PUT_POS;
    end else if (pick < 160) begin
      w.cmd = CMD_BACKSPACE;
    end else if (pick < 192) begin
      w.cmd = CMD_READ;
      // half the reads look at the cell just written
      if (pick < 176) begin
        p = (cursor_pos == 0) ? 0 : cursor_pos - 1;
        w.col = COL_W'(p % COLS);
        w.row = ROW_W'(p / COLS);
      end
    end else if (pick < 198) begin
      w.cmd = CMD_W'($urandom_range(CMD_READ + 1, CMD_MAX));
    end else begin
      w.cmd = CMD_CLEAR;
    end
    return w;
  endfunction

  // offers one command word after a random gap and predicts its result once accepted;
  // valid stays high after accept so back-to-back words need no second assignment
  task automatic send_command(input tcw_in_t w);
    int gap;
    gap = draw_gap(sender_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
    expected_results.push_back(predict_console(w));
    commands_sent++;
    if (w.cmd == CMD_READ) reads_sent++;
    if (w.cmd == CMD_CLEAR) clears_sent++;
    if (expected_results[$].scrolled) scrolls_expected++;
  endtask

  // stop offering and wait for every outstanding result word
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // only called with no command in progress
  task automatic write_colour(input logic [7:0] v);
    cfg_wen   <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wen    <= 1'b0;
    colour_reg = v;
    colour_settings++;
  endtask

  task automatic report_failure(input string what, input tcw_out_t exp, input tcw_out_t got);
    failures++;
    if (failures <= REPORT_LIMIT) begin
      $write("%0t: %s: expected col=%0d row=%0d char=%02h attr=%02h scr=%0b",
             $realtime, what, exp.cursor_col, exp.cursor_row, exp.cell_char, exp.cell_attr,
             exp.scrolled);
      $display(", got col=%0d row=%0d char=%02h attr=%02h scr=%0b",
               got.cursor_col, got.cursor_row, got.cell_char, got.cell_attr, got.scrolled);
    end
  endtask

  // result side: random stall before each word, optional long hold-off, then compare
  initial begin : result_sink
    int       wait_cycles;
    tcw_out_t exp;
    wait (!rst);
    forever begin
      wait_cycles = draw_gap(receiver_calm) + hold_request;
      hold_request = 0;
      if (wait_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      results_checked++;
      if (results_checked % 40 == 0) receiver_calm = ($urandom_range(0, 3) == 0);
      if (expected_results.size() == 0) begin
        report_failure("result word with no command pending", '0, out_word);
      end else begin
        exp = expected_results.pop_front();
        if (out_word.cursor_col !== exp.cursor_col || out_word.cursor_row !== exp.cursor_row ||
            out_word.cell_char !== exp.cell_char || out_word.cell_attr !== exp.cell_attr ||
            out_word.scrolled !== exp.scrolled)
          report_failure("result mismatch", exp, out_word);
      end
    end
  end

  // fresh screen, field extremes, newline and backspace codes, saturation,
  // scrolling, backspace at cell 0, unused codes and clear
  task automatic test_edges_after_reset();
    int code;
    write_colour(8'h00);
    send_command(make_command(CMD_READ, 8'h00, 8'h00, 0, 0));
    send_command(make_command(CMD_PUT_CUR, 8'h41, 8'h00, 0, 0));
    send_command(make_command(CMD_PUT_CUR, 8'hFF, 8'hFF, COL_MAX, ROW_MAX));
    send_command(make_command(CMD_PUT_CUR, 8'h00, 8'h80, 0, 0));
    send_command(make_command(CMD_PUT_CUR, CODE_BACKSPACE, 8'h1E, 0, 0));
    send_command(make_command(CMD_READ, 8'h00, 8'h00, 3, 0));
    send_command(make_command(CMD_PUT_CUR, CODE_NEWLINE, 8'h00, 0, 0));
    send_command(make_command(CMD_READ, 8'hFF, 8'hFF, 0, 0));
    // beyond the grid saturates to the last cell, so this one scrolls
    send_command(make_command(CMD_PUT_POS, 8'h5A, 8'h70, COL_MAX, ROW_MAX));
    send_command(make_command(CMD_READ, 8'h00, 8'h00, COL_MAX, ROW_MAX));
    send_command(make_command(CMD_READ, 8'h00, 8'h00, COLS - 1, LINES - 2));
    // newline on the last row scrolls, twice in a row
    send_command(make_command(CMD_PUT_POS, CODE_NEWLINE, 8'h00, COLS - 1, LINES - 1));
    send_command(make_command(CMD_PUT_CUR, CODE_NEWLINE, 8'h00, 0, 0));
    send_command(make_command(CMD_PUT_POS, CODE_BACKSPACE, 8'h00, 0, LINES - 1));
    send_command(make_command(CMD_BACKSPACE, 8'h00, 8'hFF, 0, 0));
    // step back into cell 0 and then try once more
    send_command(make_command(CMD_PUT_POS, 8'h78, 8'h00, 1, 0));
    send_command(make_command(CMD_BACKSPACE, 8'h00, 8'h00, 0, 0));
    send_command(make_command(CMD_BACKSPACE, 8'h00, 8'h00, 0, 0));
    send_command(make_command(CMD_BACKSPACE, 8'h00, 8'h00, 0, 0));
    send_command(make_command(CMD_READ, 8'h00, 8'h00, 0, 0));
    for (code = CMD_READ + 1; code <= CMD_MAX; code++)
      send_command(make_command(CMD_W'(code), 8'($urandom), 8'($urandom),
                                int'($urandom_range(0, COL_MAX)),
                                int'($urandom_range(0, ROW_MAX))));
    send_command(make_command(CMD_CLEAR, 8'h00, 8'h00, 0, 0));
    send_command(make_command(CMD_READ, 8'h00, 8'h00, 40, 12));
    drain_results();
  endtask

  // nonzero colour register overrides every written attribute, including clear
  task automatic test_colour_override();
    write_colour(8'hFF);
    send_command(make_command(CMD_PUT_CUR, 8'h61, 8'h00, 0, 0));
    send_command(make_command(CMD_PUT_CUR, 8'h62, 8'h42, 0, 0));
    send_command(make_command(CMD_BACKSPACE, 8'h00, 8'h00, 0, 0));
    send_command(make_command(CMD_READ, 8'h00, 8'h00, 0, 0));
    send_command(make_command(CMD_READ, 8'h00, 8'h00, 1, 0));
    send_command(make_command(CMD_CLEAR, 8'h00, 8'h00, 0, 0));
    send_command(make_command(CMD_READ, 8'h00, 8'h00, COLS - 1, LINES - 1));
    drain_results();
    write_colour(8'h01);
    send_command(make_command(CMD_PUT_CUR, 8'h63, 8'h00, 0, 0));
    send_command(make_command(CMD_READ, 8'h00, 8'h00, 0, 0));
    drain_results();
    write_colour(8'h00);
    send_command(make_command(CMD_PUT_CUR, 8'h64, 8'h00, 0, 0));
    send_command(make_command(CMD_READ, 8'h00, 8'h00, 1, 0));
    drain_results();
  endtask

  // random traffic in phases, each phase under its own colour setting
  task automatic test_random_traffic();
    int phase;
    int n;
    logic [7:0] colour;
    for (phase = 0; phase < 7; phase++) begin
      case (phase)
        0:       colour = 8'h00;
        1:       colour = 8'hFF;
        2:       colour = 8'h01;
        default: colour = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
      endcase
      write_colour(colour);
      for (n = 0; n < 200; n++) begin
        if (n % 50 == 0) sender_calm = ($urandom_range(0, 3) == 0);
        send_command(random_command());
      end
      drain_results();
    end
    sender_calm = 1'b0;
  endtask

  // receiver holds off for a long stretch while commands keep coming
  task automatic test_output_backpressure();
    int n;
    sender_calm  = 1'b1;
    hold_request = 400;
    for (n = 0; n < 24; n++) send_command(random_command());
    drain_results();
    sender_calm = 1'b0;
  endtask

  initial begin : stimulus
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_edges_after_reset();
    test_colour_override();
    test_random_traffic();
    test_output_backpressure();
    drain_results();
    // catch stray words after the last expected one
    repeat (50) @(posedge clk);
    if (expected_results.size() != 0) begin
      failures += expected_results.size();
      $display("%0d result words never arrived", expected_results.size());
    end
    $display("ran %0d commands: %0d reads, %0d clears, %0d scrolling puts, %0d colours",
             commands_sent, reads_sent, clears_sent, scrolls_expected, colour_settings);
    $display("%0d result words checked, %0d failures", results_checked, failures);
    if (failures == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  // run limit, well past the slowest legal run
  initial begin : watchdog
    #150_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

### files.f
design/tcw_pkg.sv
design/tcw_ram.sv
design/tcw_sequencer.sv
design/tcw_datapath.sv
design/text_console_cell_writer.sv
verif/text_console_cell_writer_test.sv
